FILE: rtl/ubx_frame_splitter_assert.svh
// Assertion macros shared by the frame splitter RTL.
`ifndef UBX_FRAME_SPLITTER_ASSERT_SVH
`define UBX_FRAME_SPLITTER_ASSERT_SVH

// Same-cycle implication, checked on clk_i, off while rst_ni is low.
`define UBX_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk_i, off while rst_ni is low.
`define UBX_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/ubxfs_pkg.sv
// Types and constants of the binary frame splitter.
package ubxfs_pkg;

  typedef enum logic [2:0] {
    PH_HUNT   = 3'd0,
    PH_SYNC2  = 3'd1,
    PH_CLASS  = 3'd2,
    PH_ID     = 3'd3,
    PH_LEN_LO = 3'd4,
    PH_LEN_HI = 3'd5,
    PH_BODY   = 3'd6
  } phase_e;

  typedef enum logic [1:0] {
    KIND_PASS = 2'd0,
    KIND_VEL  = 2'd1,
    KIND_POS  = 2'd2
  } kind_e;

  localparam logic [7:0] SYNC_A = 8'hB5;
  localparam logic [7:0] SYNC_B = 8'h62;
  localparam logic [7:0] ID_VEL = 8'h12;
  localparam logic [7:0] ID_POS = 8'h01;

  localparam int NUM_WORDS = 9;
  localparam int WORD_W    = 32;
  // payload bytes that land in the word store
  localparam logic [16:0] PAYLOAD_BYTES = 17'd36;

  // result queue
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  typedef logic [WORD_W-1:0] word_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
    logic       last;
  } res_t;

endpackage

FILE: rtl/ubx_frame_splitter.sv
// Binary frame splitter: pulls sync-framed binary records out of a receiver byte stream.
//
// One byte enters per item on the slave side; while the slave side does not
// stall, the block takes one byte per clock. Frames (0xB5 0x62,
// class, id, 16-bit little-endian length, payload, two checksum bytes) are
// swallowed whole; length + 2 bytes always follow the header and the checksum
// is not checked. On the final byte of a frame with id 0x12 a velocity record
// (kind 1) is emitted, with id 0x01 a position record (kind 2); other ids give
// nothing. Bytes outside frames pass through as kind 0 items, and a 0xB5 not
// followed by 0x62 gives two items (0xB5, then the second byte). Results go
// through a four-entry queue that takes up to two items a cycle and registers
// them before they are offered. The slave side stalls when fewer than two
// queue slots are free, and the byte that ends a record frame also waits while
// the previous record is still queued, since one record buffer holds its data.
// With the master side always ready the sustained rate is one byte per cycle.
// tlast marks the final item caused by one input byte.
module ubx_frame_splitter
  import ubxfs_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [7:0]   s_axis_tdata_i,   // in_byte
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // out_byte[7:0], time_of_week[39:8], north_or_x[71:40], east_or_y[103:72],
  // down_or_z[135:104], speed_total[167:136], speed_ground[199:168],
  // heading_value[231:200], accuracy_main[263:232], course_accuracy[295:264]
  output logic [295:0] m_axis_tdata_o,
  output logic [1:0]   m_axis_tuser_o,   // kind
  output logic         m_axis_tlast_o    // last
);

  `include "ubx_frame_splitter_assert.svh"

  // frame parser state
  phase_e       phase_q, phase_d;
  logic [7:0]   id_q, id_d;
  logic [15:0]  len_q, len_d;
  logic [16:0]  count_q, count_d;

  // payload words, cleared when a frame header starts
  word_t        words_q [NUM_WORDS];
  // record snapshot, already arranged in output field order
  word_t        rec_q [NUM_WORDS];
  word_t        rec_d [NUM_WORDS];
  logic         rec_busy_q;

  // result queue
  res_t              queue_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] fill_q;

  logic         in_fire, out_fire;
  logic [7:0]   in_byte;
  logic [16:0]  count_inc;
  logic         frame_end, rec_due;
  logic         clear_words, wr_en;
  logic [3:0]   word_idx;
  logic [1:0]   byte_sel;
  logic [1:0]   n_push;
  logic         rec_push;
  kind_e        rec_kind;
  res_t         res0, res1, head;

  assign in_byte   = s_axis_tdata_i;
  assign in_fire   = s_axis_tvalid_i & s_axis_tready_o;
  assign out_fire  = m_axis_tvalid_o & m_axis_tready_i;
  assign count_inc = count_q + 17'd1;
  assign frame_end = count_inc >= ({1'b0, len_q} + 17'd2);
  assign word_idx  = count_q[5:2];
  assign byte_sel  = count_q[1:0];

  // the byte that closes a record frame is known from state alone
  assign rec_due = (phase_q == PH_BODY) && frame_end && (id_q == ID_VEL || id_q == ID_POS);

  assign s_axis_tready_o = (fill_q <= QCNT_W'(QDEPTH - 2)) && !(rec_due && rec_busy_q);

  // next state
  always_comb begin
    phase_d     = phase_q;
    id_d        = id_q;
    len_d       = len_q;
    count_d     = count_q;
    clear_words = 1'b0;
    wr_en       = 1'b0;
    unique case (phase_q)
      PH_SYNC2: begin
        if (in_byte == SYNC_B) begin
          phase_d     = PH_CLASS;
          clear_words = 1'b1;
        end else begin
          phase_d = PH_HUNT;
        end
      end
      PH_CLASS: begin
        phase_d = PH_ID;
      end
      PH_ID: begin
        id_d    = in_byte;
        phase_d = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        len_d   = {8'h00, in_byte};
        phase_d = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        len_d   = {in_byte, len_q[7:0]};
        count_d = '0;
        phase_d = PH_BODY;
      end
      PH_BODY: begin
        wr_en   = (count_q < {1'b0, len_q}) && (count_q < PAYLOAD_BYTES);
        count_d = count_inc;
        if (frame_end) begin
          phase_d = PH_HUNT;
          count_d = '0;
        end
      end
      default: begin
        phase_d = (in_byte == SYNC_A) ? PH_SYNC2 : PH_HUNT;
      end
    endcase
  end

  // results of the current byte
  always_comb begin
    n_push   = 2'd0;
    rec_push = 1'b0;
    rec_kind = KIND_VEL;
    res0     = res_t'{kind: KIND_PASS, data: in_byte, last: 1'b1};
    res1     = res_t'{kind: KIND_PASS, data: in_byte, last: 1'b1};
    unique case (phase_q)
      PH_SYNC2: begin
        if (in_byte != SYNC_B) begin
          n_push = 2'd2;
          res0   = res_t'{kind: KIND_PASS, data: SYNC_A, last: 1'b0};
        end
      end
      PH_CLASS, PH_ID, PH_LEN_LO, PH_LEN_HI: begin
        n_push = 2'd0;
      end
      PH_BODY: begin
        if (rec_due) begin
          n_push   = 2'd1;
          rec_push = 1'b1;
          rec_kind = (id_q == ID_VEL) ? KIND_VEL : KIND_POS;
          res0     = res_t'{kind: rec_kind, data: 8'h00, last: 1'b1};
        end
      end
      default: begin
        if (in_byte != SYNC_A) begin
          n_push = 2'd1;
        end
      end
    endcase
  end

  // record fields: velocity maps words straight, position keeps
  // words 0..3 and moves word 4 to the accuracy slot
  always_comb begin
    for (int i = 0; i < NUM_WORDS; i++) begin
      rec_d[i] = words_q[i];
    end
    if (rec_kind == KIND_POS) begin
      rec_d[4] = '0;
      rec_d[5] = '0;
      rec_d[6] = '0;
      rec_d[7] = words_q[4];
      rec_d[8] = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      id_q    <= '0;
      len_q   <= '0;
      count_q <= '0;
    end else if (in_fire) begin
      phase_q <= phase_d;
      id_q    <= id_d;
      len_q   <= len_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int w = 0; w < NUM_WORDS; w++) begin
      for (int k = 0; k < 4; k++) begin
        if (in_fire && clear_words) begin
          words_q[w][8*k +: 8] <= 8'h00;
        end else if (in_fire && wr_en && word_idx == 4'(w) && byte_sel == 2'(k)) begin
          words_q[w][8*k +: 8] <= in_byte;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && rec_push) begin
      for (int i = 0; i < NUM_WORDS; i++) begin
        rec_q[i] <= rec_d[i];
      end
    end
  end

  // queue payload
  always_ff @(posedge clk_i) begin
    if (in_fire && n_push != 2'd0) begin
      queue_q[wr_ptr_q] <= res0;
    end
    if (in_fire && n_push == 2'd2) begin
      queue_q[wr_ptr_q + QPTR_W'(1)] <= res1;
    end
  end

  // queue control and record ownership
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      fill_q     <= '0;
      rec_busy_q <= 1'b0;
    end else begin
      if (in_fire) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(n_push);
      end
      if (out_fire) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      fill_q <= fill_q + QCNT_W'(in_fire ? n_push : 2'd0) - QCNT_W'(out_fire);
      if (out_fire && head.kind != KIND_PASS) begin
        rec_busy_q <= 1'b0;
      end
      if (in_fire && rec_push) begin
        rec_busy_q <= 1'b1;
      end
    end
  end

  assign head            = queue_q[rd_ptr_q];
  assign m_axis_tvalid_o = fill_q != '0;
  assign m_axis_tuser_o  = head.kind;
  assign m_axis_tlast_o  = head.last;

  always_comb begin
    m_axis_tdata_o[7:0] = head.data;
    for (int i = 0; i < NUM_WORDS; i++) begin
      m_axis_tdata_o[8 + WORD_W*i +: WORD_W] = (head.kind == KIND_PASS) ? '0 : rec_q[i];
    end
  end

  `UBX_ASSERT_SAME(a_fill_bound, 1'b1, fill_q <= QCNT_W'(QDEPTH), "result queue overfilled")
  `UBX_ASSERT_SAME(a_rec_owned, m_axis_tvalid_o && head.kind != KIND_PASS, rec_busy_q,
                   "record at queue head without record buffer")
  `UBX_ASSERT_NEXT(a_rec_taken, in_fire && rec_due, rec_busy_q,
                   "record frame closed but record buffer not claimed")
  `UBX_ASSERT_NEXT(a_bad_sync_two,
                   in_fire && phase_q == PH_SYNC2 && in_byte != SYNC_B && !out_fire,
                   fill_q == $past(fill_q) + QCNT_W'(2),
                   "broken sync did not queue two items")

endmodule

FILE: test/tb_top.sv
// Self-checking testbench for the binary frame splitter (frames, records, passthrough text).
module tb_top;
  import ubxfs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // run ends here if the block hangs; the longest correct run is well below
  localparam int CYCLE_LIMIT = 600000;
  localparam int DATA_W      = 296;
  localparam int NUM_FIELDS  = 10;

  // payload fill used by the frame sender
  typedef enum int {
    PAT_RANDOM,
    PAT_ONES,
    PAT_MIN_NEG
  } fill_e;

  // one expected output item
  typedef struct {
    kind_e             kind;
    logic              last;
    logic [DATA_W-1:0] data;
  } split_item_t;

  logic              clk_i  = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_valid = 1'b0;
  logic [7:0]        s_data  = 8'h00;
  logic              s_ready;
  logic              m_valid;
  logic              m_ready = 1'b0;
  logic [DATA_W-1:0] m_data;  // out_byte, then the nine 32-bit words
  logic [1:0]        m_user;  // kind
  logic              m_last;  // last

  ubx_frame_splitter dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),   // in_byte
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),   // out_byte[7:0], then 9 words of 32 bits from bit 8 up
    .m_axis_tuser_o  (m_user),   // kind
    .m_axis_tlast_o  (m_last)    // last
  );

  always #1 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Parser state mirrored from the byte stream
  // ---------------------------------------------------------------------------
  phase_e      parse_phase = PH_HUNT;
  logic [7:0]  parse_id    = 8'h00;
  logic [15:0] parse_len   = 16'h0000;
  logic [16:0] parse_count = 17'h0;
  word_t       payload_words [NUM_WORDS];

  split_item_t split_results [$];

  // idle and stall controls, percent of cycles
  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  int hold_req       = 0;  // set by a test at a rising edge, taken by the sink
  int hold_left      = 0;

  int errors       = 0;
  int bytes_sent   = 0;
  int passes_seen  = 0;
  int vel_seen     = 0;
  int pos_seen     = 0;
  int cycle_count  = 0;

  string field_names [NUM_FIELDS] = '{
    "out_byte", "time_of_week", "north_or_x", "east_or_y", "down_or_z",
    "speed_total", "speed_ground", "heading_value", "accuracy_main", "course_accuracy"
  };

  function automatic logic [31:0] field_of(input logic [DATA_W-1:0] d, input int f);
    if (f == 0)
      return {24'h0, d[7:0]};
    return d[8 + 32*(f-1) +: 32];
  endfunction

  function automatic void push_pass(input logic [7:0] b, input logic last);
    split_item_t it;
    it.kind = KIND_PASS;
    it.last = last;
    it.data = '0;
    it.data[7:0] = b;
    split_results.push_back(it);
  endfunction

  // record layout: words 0..3 always; velocity adds 4..8, position puts word 4
  // into the accuracy slot
  function automatic void push_record(input kind_e k);
    split_item_t it;
    it.kind = k;
    it.last = 1'b1;
    it.data = '0;
    for (int w = 0; w < 4; w++)
      it.data[8 + 32*w +: 32] = payload_words[w];
    if (k == KIND_VEL) begin
      for (int w = 4; w < NUM_WORDS; w++)
        it.data[8 + 32*w +: 32] = payload_words[w];
    end else begin
      it.data[8 + 32*7 +: 32] = payload_words[4];
    end
    split_results.push_back(it);
  endfunction

  // advance the mirrored parser by one accepted byte
  function automatic void split_byte(input logic [7:0] b);
    case (parse_phase)
      PH_SYNC2: begin
        if (b == SYNC_B) begin
          parse_phase = PH_CLASS;
          for (int w = 0; w < NUM_WORDS; w++)
            payload_words[w] = '0;
        end else begin
          // broken sync: both bytes go out, hunting restarts
          push_pass(SYNC_A, 1'b0);
          push_pass(b, 1'b1);
          parse_phase = PH_HUNT;
        end
      end
      PH_CLASS: parse_phase = PH_ID;
      PH_ID: begin
        parse_id    = b;
        parse_phase = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        parse_len   = {8'h00, b};
        parse_phase = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        parse_len[15:8] = b;
        parse_count     = '0;
        parse_phase     = PH_BODY;
      end
      PH_BODY: begin
        // checksum bytes and bytes past the word store are not payload
        if (parse_count < {1'b0, parse_len} && parse_count < PAYLOAD_BYTES)
          payload_words[parse_count[16:2]][parse_count[1:0]*8 +: 8] = b;
        parse_count = parse_count + 17'd1;
        if (int'(parse_count) >= int'(parse_len) + 2) begin
          if (parse_id == ID_VEL)
            push_record(KIND_VEL);
          else if (parse_id == ID_POS)
            push_record(KIND_POS);
          parse_phase = PH_HUNT;
          parse_count = '0;
        end
      end
      default: begin
        if (b == SYNC_A)
          parse_phase = PH_SYNC2;
        else
          push_pass(b, 1'b1);
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: called at a falling edge, returns at a falling edge with tvalid
  // still high so back-to-back items never toggle it within one step
  // ---------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < src_idle_pct) begin
      s_valid <= 1'b0;
      @(negedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= b;
    do
      @(posedge clk_i);
    while (!s_ready);
    split_byte(b);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  function automatic logic [7:0] payload_byte(input fill_e fill, input int idx);
    case (fill)
      PAT_ONES:    return 8'hFF;
      PAT_MIN_NEG: return (idx % 4 == 3) ? 8'h80 : 8'h00;
      default:     return 8'($urandom);
    endcase
  endfunction

  // sync, class, id, length, payload, two checksum bytes (random, never checked)
  task automatic send_frame(input logic [7:0] cls, input logic [7:0] id,
                            input logic [15:0] len, input fill_e fill);
    send_byte(SYNC_A);
    send_byte(SYNC_B);
    send_byte(cls);
    send_byte(id);
    send_byte(len[7:0]);
    send_byte(len[15:8]);
    for (int i = 0; i < int'(len); i++)
      send_byte(payload_byte(fill, i));
    send_byte(8'($urandom));
    send_byte(8'($urandom));
  endtask

  // ---------------------------------------------------------------------------
  // Sink: ready changes at the falling edge; a long hold-off is counted here
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      m_ready <= 1'b0;
      hold_left--;
    end else begin
      m_ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // compare each accepted output item with the oldest expectation
  always @(posedge clk_i) begin
    split_item_t want;
    if (rst_ni && m_valid && m_ready) begin
      if (split_results.size() == 0) begin
        $error("output item with none expected: kind %0d data %h", m_user, m_data);
        errors++;
      end else begin
        want = split_results.pop_front();
        if (m_user !== want.kind) begin
          $error("kind: expected %0d, actual %0d", want.kind, m_user);
          errors++;
        end
        if (m_last !== want.last) begin
          $error("last: expected %0b, actual %0b", want.last, m_last);
          errors++;
        end
        for (int f = 0; f < NUM_FIELDS; f++) begin
          if (field_of(m_data, f) !== field_of(want.data, f)) begin
            $error("%s: expected %h, actual %h", field_names[f],
                   field_of(want.data, f), field_of(m_data, f));
            errors++;
          end
        end
        case (want.kind)
          KIND_VEL: vel_seen++;
          KIND_POS: pos_seen++;
          default:  passes_seen++;
        endcase
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("ubx_frame_splitter verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_text_passthrough();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h55);
    send_byte(8'hAA);
    send_byte(SYNC_B);  // second sync byte alone is plain text
    send_byte(8'hB4);
  endtask

  task automatic test_broken_sync();
    send_byte(SYNC_A);
    send_byte(8'h00);
    // a second 0xB5 is passed out too, not taken as a new sync
    send_byte(SYNC_A);
    send_byte(SYNC_A);
    send_byte(SYNC_A);
    send_byte(8'hFF);
  endtask

  task automatic test_velocity_record();
    send_frame(8'h01, ID_VEL, 16'd36, PAT_ONES);
  endtask

  task automatic test_position_record();
    send_frame(8'h01, ID_POS, 16'd20, PAT_MIN_NEG);
  endtask

  task automatic test_frame_edge_cases();
    send_frame(8'h01, ID_VEL, 16'd5, PAT_RANDOM);   // short payload, rest reads zero
    send_frame(8'h01, ID_POS, 16'd0, PAT_RANDOM);   // zero length, record on checksum
    send_frame(8'h01, ID_VEL, 16'd45, PAT_RANDOM);  // bytes past the store ignored
    send_frame(8'h01, 8'h30, 16'd8, PAT_RANDOM);    // unknown id, nothing out
    send_frame(8'hFF, ID_POS, 16'd20, PAT_RANDOM);  // class byte has no effect
    send_frame(8'h00, 8'h00, 16'd2, PAT_RANDOM);
  endtask

  // length with the high byte in use
  task automatic test_max_length();
    send_frame(8'h0A, ID_VEL, 16'h0100, PAT_RANDOM);
  endtask

  // sink holds off while text keeps coming, so the result queue fills and
  // the input side must stall
  task automatic test_backpressure();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    s_valid <= 1'b0;
    @(posedge clk_i);
    hold_req = 300;
    @(negedge clk_i);
    for (int i = 0; i < 16; i++)
      send_byte(8'($urandom_range(8'hB4)));
    send_frame(8'h01, ID_VEL, 16'd36, PAT_RANDOM);
    send_frame(8'h01, ID_POS, 16'd20, PAT_RANDOM);
  endtask

  // mostly well-formed frames with random content, plus text and broken syncs
  task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                     input int n_bytes);
    int start;
    int pick;
    logic [15:0] len;
    logic [7:0]  id;
    logic [7:0]  b;
    src_idle_pct   = idle_pct;
    sink_stall_pct = stall_pct;
    start = bytes_sent;
    while (bytes_sent - start < n_bytes) begin
      pick = $urandom_range(99);
      if (pick < 60) begin
        len = 16'($urandom_range(44));
        case ($urandom_range(4))
          0, 1:    id = ID_VEL;
          2, 3:    id = ID_POS;
          default: id = 8'($urandom);
        endcase
        send_frame(8'($urandom), id, len, PAT_RANDOM);
      end else if (pick < 85) begin
        repeat ($urandom_range(1, 4))
          send_byte(8'($urandom));
      end else begin
        send_byte(SYNC_A);
        if ($urandom_range(3) == 0) begin
          send_byte(SYNC_A);
        end else begin
          b = 8'($urandom);
          if (b == SYNC_B)
            b = 8'h63;
          send_byte(b);
        end
      end
    end
  endtask

  initial begin
    for (int w = 0; w < NUM_WORDS; w++)
      payload_words[w] = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_text_passthrough();
    test_broken_sync();
    test_velocity_record();
    test_position_record();
    test_frame_edge_cases();
    test_max_length();
    test_backpressure();
    test_random_traffic(0, 0, 40);
    test_random_traffic(77, 0, 40);
    test_random_traffic(0, 77, 40);
    test_random_traffic(23, 23, 40);

    s_valid <= 1'b0;
    sink_stall_pct = 0;
    while (split_results.size() != 0)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("Sent %0d bytes; checked %0d passthrough, %0d velocity, %0d position items.",
             bytes_sent, passes_seen, vel_seen, pos_seen);
    $display("Covered broken syncs, short/zero/long frames, idle phases, sink hold-off.");
    if (errors == 0 && split_results.size() == 0) begin
      $display("ubx_frame_splitter verification clean");
    end else begin
      $display("ubx_frame_splitter verification failed");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl
rtl/ubxfs_pkg.sv
rtl/ubx_frame_splitter.sv
test/tb_top.sv
